/* src/llp_pkg.sv */
// package: constants, state type and tables of the lookahead path block
`timescale 1ns / 1ps

package llp_pkg;

  localparam int unsigned PATH_DEPTH   = 1024;
  localparam int unsigned MAX_EMIT     = 64;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned MIN_POINTS   = 3;

  localparam int unsigned ADDR_W  = $clog2(PATH_DEPTH);
  localparam int unsigned CNT_W   = $clog2(PATH_DEPTH + 1);
  localparam int unsigned EMIT_W  = $clog2(MAX_EMIT + 1);
  localparam int unsigned STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIFF_W  = 25;
  localparam int unsigned SQ_W    = 50;
  localparam int unsigned SEG_W   = 24;
  localparam int unsigned CFG_W   = 23;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned TRIG_W  = 33;
  localparam int unsigned ANG_W   = 34;
  localparam int unsigned PROD_W  = 58;
  localparam int unsigned SUM_W   = 59;
  localparam int unsigned TRAV_W  = 32;
  localparam int unsigned FRAC    = 30;
  localparam int unsigned SQRT_TOP = 48;

  localparam logic [TRIG_W-1:0] CORDIC_X0 = TRIG_W'(652032874);
  localparam logic [33:0]       ANGLE_K   = 34'd6746518852;

  localparam logic [CFG_W-1:0] HORIZON_RST = CFG_W'(6144);
  localparam logic [CFG_W-1:0] MAXDEV_RST  = CFG_W'(768);

  localparam logic CFG_HORIZON = 1'b0;
  localparam logic CFG_MAXDEV  = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_PATH = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_DIFF,
    ST_LD_SQ,
    ST_LD_SUM,
    ST_SQRT,
    ST_LD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DEV,
    ST_COR_INIT,
    ST_COR,
    ST_QUAD,
    ST_W_RD,
    ST_W_D,
    ST_W_MUL,
    ST_W_OUT,
    ST_REPORT
  } state_t;

  function automatic logic [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic [ANG_W-1:0] a;
    unique case (i)
      5'd0:  a = ANG_W'(843314857);
      5'd1:  a = ANG_W'(497837829);
      5'd2:  a = ANG_W'(263043837);
      5'd3:  a = ANG_W'(133525159);
      5'd4:  a = ANG_W'(67021687);
      5'd5:  a = ANG_W'(33543516);
      5'd6:  a = ANG_W'(16775851);
      5'd7:  a = ANG_W'(8388437);
      5'd8:  a = ANG_W'(4194283);
      5'd9:  a = ANG_W'(2097149);
      5'd10: a = ANG_W'(1048576);
      5'd11: a = ANG_W'(524288);
      5'd12: a = ANG_W'(262144);
      5'd13: a = ANG_W'(131072);
      5'd14: a = ANG_W'(65536);
      5'd15: a = ANG_W'(32768);
      5'd16: a = ANG_W'(16384);
      5'd17: a = ANG_W'(8192);
      5'd18: a = ANG_W'(4096);
      5'd19: a = ANG_W'(2048);
      5'd20: a = ANG_W'(1024);
      5'd21: a = ANG_W'(512);
      5'd22: a = ANG_W'(256);
      5'd23: a = ANG_W'(128);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* src/local_lookahead_path.sv */
// top level: closed path store with nearest point search and lookahead walk
`timescale 1ns / 1ps

// channel   | ports                                           | handshake
// input     | in_req_type in_coord_x/y in_heading in_restart  | start while !busy
// result    | out_status out_local_x/y out_point_index out_last | out_valid, 1 cycle
// config    | cfg_index cfg_wdata                             | cfg_we, no wait
//
// load: segment lengths by iterative square root, one for the first point and two for each later one
// query: a scan of all stored points (one memory read per cycle), a CORDIC iteration
//   for sin and cos, then per emitted point a memory read, diff, rotate and round
// reset: synchronous, clears the point count and loads register defaults
// results are strobed out; the receiver cannot stall them

module local_lookahead_path (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic signed [llp_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [llp_pkg::COORD_W-1:0] in_coord_y,
  input  logic        [llp_pkg::HEAD_W-1:0]  in_heading,
  input  logic                               in_restart,
  output logic                               out_valid,
  output logic        [1:0]                  out_status,
  output logic signed [llp_pkg::COORD_W-1:0] out_local_x,
  output logic signed [llp_pkg::COORD_W-1:0] out_local_y,
  output logic        [llp_pkg::IDX_W-1:0]   out_point_index,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic        [llp_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int unsigned AW  = llp_pkg::ADDR_W;
  localparam int unsigned CW  = llp_pkg::CNT_W;
  localparam int unsigned XW  = llp_pkg::COORD_W;
  localparam int unsigned DW  = llp_pkg::DIFF_W;
  localparam int unsigned QW  = llp_pkg::SQ_W;
  localparam int unsigned SW  = llp_pkg::SEG_W;
  localparam int unsigned TW  = llp_pkg::TRIG_W;
  localparam int unsigned GW  = llp_pkg::ANG_W;
  localparam int unsigned PW  = llp_pkg::PROD_W;
  localparam int unsigned UW  = llp_pkg::SUM_W;
  localparam int unsigned VW  = llp_pkg::TRAV_W;
  localparam int unsigned EW  = llp_pkg::EMIT_W;
  localparam int unsigned NW  = llp_pkg::STEP_W;

  function automatic logic signed [XW-1:0] rnd_sat(input logic signed [UW-1:0] v);
    logic signed [UW-1:0] t;
    logic signed [UW-1:0] s;
    logic signed [XW-1:0] r;
    t = v + {{(UW-llp_pkg::FRAC){1'b0}}, 1'b1, {(llp_pkg::FRAC-1){1'b0}}};
    s = t >>> llp_pkg::FRAC;
    if (s > 8388607) begin
      r = {1'b0, {(XW-1){1'b1}}};
    end else if (s < -8388608) begin
      r = {1'b1, {(XW-1){1'b0}}};
    end else begin
      r = s[XW-1:0];
    end
    return r;
  endfunction

  llp_pkg::state_t state_r, state_nxt;

  logic [2*XW-1:0] pt_mem [llp_pkg::PATH_DEPTH];
  logic [SW-1:0]   seg_mem [llp_pkg::PATH_DEPTH];
  logic [2*XW-1:0] pt_rd_r;
  logic [SW-1:0]   seg_rd_r;

  logic [CW-1:0]   count_r;
  logic [llp_pkg::CFG_W-1:0] horizon_r, maxdev_r;
  logic            out_valid_r;

  logic signed [XW-1:0] pos_x_r, pos_y_r, prev_x_r, prev_y_r, p0_x_r, p0_y_r;
  logic [llp_pkg::HEAD_W-1:0] hd_r;
  logic [AW-1:0]   ld_n_r;
  logic            phase_r;

  logic signed [DW-1:0] dx_r, dy_r;
  logic [QW-1:0]   sqx_r, sqy_r;
  logic [QW-1:0]   rem_r, res_r, bit_r;
  logic [2*llp_pkg::CFG_W-1:0] md_r;

  logic [CW-1:0]   scan_i_r;
  logic            v1_r, v2_r, v3_r;
  logic [AW-1:0]   i1_r, i2_r, i3_r;
  logic [QW-1:0]   best_d_r;
  logic [AW-1:0]   best_i_r;

  logic signed [TW-1:0] x_r, y_r, co_r, si_r;
  logic signed [GW-1:0] z_r;
  logic [NW-1:0]   step_r;

  logic [AW-1:0]   idx_r;
  logic [EW-1:0]   k_r;
  logic [VW-1:0]   trav_r;
  logic signed [PW-1:0] p_cx_r, p_sy_r, p_cy_r, p_sx_r;

  logic [1:0]      err_r;
  logic [1:0]      status_r;
  logic signed [XW-1:0] lx_r, ly_r;
  logic [llp_pkg::IDX_W-1:0] pidx_r;
  logic            last_r;

  logic            accept, is_load, load_ok;
  logic [AW-1:0]   load_n;
  logic [AW-1:0]   rd_addr;
  logic            issue;
  logic signed [XW-1:0] ax, ay, bx, by;
  logic signed [QW-1:0] sqx_w, sqy_w;
  logic [QW-1:0]   dsum, sq_try;
  logic [SW-1:0]   root_sat;
  logic            seg_we;
  logic [AW-1:0]   seg_waddr;
  logic [46:0]     zmul;
  logic signed [TW-1:0] xs, ys;
  logic signed [GW-1:0] at;
  logic [VW-1:0]   trav_nxt;
  logic [CW-1:0]   idx_p1;
  logic [AW-1:0]   idx_wrap;
  logic            walk_last;
  logic            emit;
  logic            scan_end;

  assign busy       = (state_r != llp_pkg::ST_IDLE);
  assign accept     = start & ~busy;
  assign is_load    = (in_req_type == llp_pkg::REQ_LOAD);
  assign load_ok    = in_restart | (count_r < CW'(llp_pkg::PATH_DEPTH));
  assign load_n     = in_restart ? '0 : count_r[AW-1:0];
  assign scan_end   = (scan_i_r == count_r - CW'(1));

  assign sqx_w      = dx_r * dx_r;
  assign sqy_w      = dy_r * dy_r;
  assign dsum       = sqx_r + sqy_r;
  assign sq_try     = res_r + bit_r;
  assign root_sat   = (res_r[QW-1:SW] != '0) ? {SW{1'b1}} : res_r[SW-1:0];
  assign zmul       = 47'(hd_r[13:0]) * 47'(llp_pkg::ANGLE_K);
  assign xs         = x_r >>> step_r;
  assign ys         = y_r >>> step_r;
  assign at         = llp_pkg::atan_q30(5'(step_r));
  assign trav_nxt   = trav_r + VW'(seg_rd_r);
  assign idx_p1     = CW'(idx_r) + CW'(1);
  assign idx_wrap   = (idx_p1 >= count_r) ? '0 : idx_p1[AW-1:0];
  assign walk_last  = !((trav_nxt <= VW'(horizon_r)) &&
                        (32'(k_r) + 32'd1 < 32'(count_r)) &&
                        (32'(k_r) + 32'd1 < 32'(llp_pkg::MAX_EMIT)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      llp_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_load) begin
            if (load_ok) state_nxt = llp_pkg::ST_LD_DIFF;
          end else if (count_r < CW'(llp_pkg::MIN_POINTS)) begin
            state_nxt = llp_pkg::ST_REPORT;
          end else begin
            state_nxt = llp_pkg::ST_SCAN;
          end
        end
      end
      llp_pkg::ST_LD_DIFF: state_nxt = llp_pkg::ST_LD_SQ;
      llp_pkg::ST_LD_SQ:   state_nxt = llp_pkg::ST_LD_SUM;
      llp_pkg::ST_LD_SUM:  state_nxt = llp_pkg::ST_SQRT;
      llp_pkg::ST_SQRT:    if (bit_r == '0) state_nxt = llp_pkg::ST_LD_WR;
      llp_pkg::ST_LD_WR:   state_nxt = phase_r ? llp_pkg::ST_IDLE : llp_pkg::ST_LD_DIFF;
      llp_pkg::ST_SCAN:    if (scan_end) state_nxt = llp_pkg::ST_DRAIN;
      llp_pkg::ST_DRAIN:   if (!(v1_r | v2_r | v3_r)) state_nxt = llp_pkg::ST_DEV;
      llp_pkg::ST_DEV: begin
        state_nxt = (best_d_r > QW'(md_r)) ? llp_pkg::ST_REPORT : llp_pkg::ST_COR_INIT;
      end
      llp_pkg::ST_COR_INIT: state_nxt = llp_pkg::ST_COR;
      llp_pkg::ST_COR: begin
        if (step_r == NW'(llp_pkg::CORDIC_STEPS - 1)) state_nxt = llp_pkg::ST_QUAD;
      end
      llp_pkg::ST_QUAD:  state_nxt = llp_pkg::ST_W_RD;
      llp_pkg::ST_W_RD:  state_nxt = llp_pkg::ST_W_D;
      llp_pkg::ST_W_D:   state_nxt = llp_pkg::ST_W_MUL;
      llp_pkg::ST_W_MUL: state_nxt = llp_pkg::ST_W_OUT;
      llp_pkg::ST_W_OUT: state_nxt = walk_last ? llp_pkg::ST_IDLE : llp_pkg::ST_W_RD;
      llp_pkg::ST_REPORT: state_nxt = llp_pkg::ST_IDLE;
      default: state_nxt = llp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_addr   = idx_r;
    issue     = 1'b0;
    ax        = pt_rd_r[2*XW-1:XW];
    ay        = pt_rd_r[XW-1:0];
    bx        = pos_x_r;
    by        = pos_y_r;
    seg_we    = 1'b0;
    seg_waddr = phase_r ? ld_n_r : ld_n_r - AW'(1);
    emit      = 1'b0;
    unique case (state_r)
      llp_pkg::ST_LD_DIFF: begin
        ax = pos_x_r;
        ay = pos_y_r;
        bx = phase_r ? p0_x_r : prev_x_r;
        by = phase_r ? p0_y_r : prev_y_r;
      end
      llp_pkg::ST_LD_WR: seg_we = 1'b1;
      llp_pkg::ST_SCAN: begin
        rd_addr = scan_i_r[AW-1:0];
        issue   = 1'b1;
      end
      llp_pkg::ST_W_OUT, llp_pkg::ST_REPORT: emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && load_ok) pt_mem[load_n] <= {in_coord_x, in_coord_y};
    pt_rd_r <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_waddr] <= root_sat;
    seg_rd_r <= seg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llp_pkg::ST_IDLE;
      count_r     <= '0;
      horizon_r   <= llp_pkg::HORIZON_RST;
      maxdev_r    <= llp_pkg::MAXDEV_RST;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      if (cfg_we) begin
        if (cfg_index == llp_pkg::CFG_HORIZON) horizon_r <= cfg_wdata;
        else maxdev_r <= cfg_wdata;
      end
      if (accept && is_load && load_ok) count_r <= CW'(load_n) + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= DW'(ax) - DW'(bx);
    dy_r  <= DW'(ay) - DW'(by);
    sqx_r <= $unsigned(sqx_w);
    sqy_r <= $unsigned(sqy_w);
    md_r  <= maxdev_r * maxdev_r;
    i1_r  <= scan_i_r[AW-1:0];
    i2_r  <= i1_r;
    i3_r  <= i2_r;

    if (v3_r && (dsum < best_d_r)) begin
      best_d_r <= dsum;
      best_i_r <= i3_r;
    end

    unique case (state_r)
      llp_pkg::ST_IDLE: begin
        if (accept) begin
          pos_x_r  <= in_coord_x;
          pos_y_r  <= in_coord_y;
          hd_r     <= in_heading;
          ld_n_r   <= load_n;
          phase_r  <= (load_n == '0);
          scan_i_r <= '0;
          best_d_r <= '1;
          err_r    <= llp_pkg::STATUS_NO_PATH;
          if (is_load && load_n == '0) begin
            p0_x_r <= in_coord_x;
            p0_y_r <= in_coord_y;
          end
        end
      end
      llp_pkg::ST_LD_SUM: begin
        rem_r <= dsum;
        res_r <= '0;
        bit_r <= QW'(1) << llp_pkg::SQRT_TOP;
      end
      llp_pkg::ST_SQRT: begin
        if (bit_r != '0) begin
          if (rem_r >= sq_try) begin
            rem_r <= rem_r - sq_try;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      llp_pkg::ST_LD_WR: begin
        phase_r <= 1'b1;
        if (phase_r) begin
          prev_x_r <= pos_x_r;
          prev_y_r <= pos_y_r;
        end
      end
      llp_pkg::ST_SCAN: scan_i_r <= scan_i_r + CW'(1);
      llp_pkg::ST_DEV: err_r <= llp_pkg::STATUS_OUTSIDE;
      llp_pkg::ST_COR_INIT: begin
        x_r    <= llp_pkg::CORDIC_X0;
        y_r    <= '0;
        z_r    <= GW'(zmul >> 16);
        step_r <= '0;
      end
      llp_pkg::ST_COR: begin
        if (!z_r[GW-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        step_r <= step_r + NW'(1);
      end
      llp_pkg::ST_QUAD: begin
        unique case (hd_r[15:14])
          2'd0: begin co_r <= x_r;  si_r <= y_r;  end
          2'd1: begin co_r <= -y_r; si_r <= x_r;  end
          2'd2: begin co_r <= -x_r; si_r <= -y_r; end
          default: begin co_r <= y_r; si_r <= -x_r; end
        endcase
        idx_r  <= best_i_r;
        k_r    <= '0;
        trav_r <= '0;
      end
      llp_pkg::ST_W_MUL: begin
        p_cx_r <= co_r * dx_r;
        p_sy_r <= si_r * dy_r;
        p_cy_r <= co_r * dy_r;
        p_sx_r <= si_r * dx_r;
      end
      llp_pkg::ST_W_OUT: begin
        k_r    <= k_r + EW'(1);
        trav_r <= trav_nxt;
        idx_r  <= idx_wrap;
      end
      default: ;
    endcase

    if (state_r == llp_pkg::ST_W_OUT) begin
      status_r <= llp_pkg::STATUS_OK;
      lx_r     <= rnd_sat(UW'(p_cx_r) + UW'(p_sy_r));
      ly_r     <= rnd_sat(UW'(p_cy_r) - UW'(p_sx_r));
      pidx_r   <= llp_pkg::IDX_W'(idx_r);
      last_r   <= walk_last;
    end else if (state_r == llp_pkg::ST_REPORT) begin
      status_r <= err_r;
      lx_r     <= '0;
      ly_r     <= '0;
      pidx_r   <= '0;
      last_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_local_x     = lx_r;
  assign out_local_y     = ly_r;
  assign out_point_index = pidx_r;
  assign out_last        = last_r;

endmodule

/* src/llp_chk.sv */
// checker: port level properties of the lookahead path block, with bind
`timescale 1ns / 1ps

module llp_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_req_type,
  input logic                               out_valid,
  input logic        [1:0]                  out_status,
  input logic signed [llp_pkg::COORD_W-1:0] out_local_x,
  input logic signed [llp_pkg::COORD_W-1:0] out_local_y,
  input logic        [llp_pkg::IDX_W-1:0]   out_point_index,
  input logic                               out_last
);

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == llp_pkg::REQ_QUERY |=> busy)
    else $error("query item not taken up");

  a_out_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != llp_pkg::STATUS_OK |->
      out_last && out_local_x == 0 && out_local_y == 0 && out_point_index == 0)
    else $error("status result malformed");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after last item");

endmodule

bind local_lookahead_path llp_chk u_llp_chk (.*);

/* test/local_lookahead_path_test.sv */
// testbench: local_lookahead_path load, nearest point search and lookahead walk checks
`timescale 1ns / 1ps

module local_lookahead_path_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int COORD_MAX      = 8388607;
  localparam int COORD_MIN      = -8388608;
  localparam int CFG_MAX        = 8388607;
  localparam int LONG_POINTS    = 200;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] lx;
    logic [23:0] ly;
    logic [9:0]  idx;
    logic        last;
  } track_point_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_req_type;
  logic signed [llp_pkg::COORD_W-1:0] in_coord_x;
  logic signed [llp_pkg::COORD_W-1:0] in_coord_y;
  logic [llp_pkg::HEAD_W-1:0] in_heading;
  logic in_restart;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [llp_pkg::COORD_W-1:0] out_local_x;
  logic signed [llp_pkg::COORD_W-1:0] out_local_y;
  logic [llp_pkg::IDX_W-1:0] out_point_index;
  logic out_last;
  logic cfg_we;
  logic cfg_index;
  logic [llp_pkg::CFG_W-1:0] cfg_wdata;

  local_lookahead_path i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_heading(in_heading), .in_restart(in_restart),
    .out_valid(out_valid), .out_status(out_status), .out_local_x(out_local_x),
    .out_local_y(out_local_y), .out_point_index(out_point_index), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // model state
  longint path_xs[llp_pkg::PATH_DEPTH];
  longint path_ys[llp_pkg::PATH_DEPTH];
  longint unsigned seg_lens[llp_pkg::PATH_DEPTH];
  int unsigned num_points;
  longint unsigned horizon;
  longint unsigned max_dev;
  longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                           524288, 262144, 131072, 65536, 32768};

  track_point_t track_q[$];
  int errors;
  int idle_pct;
  int quiet_cycles;

  // own copy of the stored points, for aiming poses
  longint aim_x[$];
  longint aim_y[$];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx, longint by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned span_len(int unsigned a, int unsigned b);
    longint unsigned r;
    r = int_sqrt(sq_dist(path_xs[a], path_ys[a], path_xs[b], path_ys[b]));
    return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
  endfunction

  function automatic void heading_trig(int unsigned hd, output longint co, output longint si);
    int unsigned q;
    longint z;
    longint x;
    longint y;
    longint nx;
    q = (hd >> 14) & 3;
    z = (longint'(hd & 16'h3FFF) * 64'sd6746518852) >>> 16;
    x = 652032874;
    y = 0;
    for (int i = 0; i < llp_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
    end
    case (q)
      0: begin co = x;  si = y;  end
      1: begin co = -y; si = x;  end
      2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic logic [23:0] round_clip(longint v);
    longint r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[23:0];
  endfunction

  function automatic void push_track(logic [1:0] st, logic [23:0] lx, logic [23:0] ly,
                                     logic [9:0] idx, logic last);
    track_point_t t;
    t.status = st;
    t.lx = lx;
    t.ly = ly;
    t.idx = idx;
    t.last = last;
    track_q = {track_q, t};
  endfunction

  function automatic void predict_path(logic rt, longint px, longint py, int unsigned hd,
                                       logic rs);
    int unsigned n;
    int unsigned best;
    int unsigned idx;
    int unsigned k;
    longint unsigned best_d;
    longint unsigned d;
    longint unsigned travelled;
    longint co;
    longint si;
    longint dx;
    longint dy;
    if (rt == llp_pkg::REQ_LOAD) begin
      if (rs) num_points = 0;
      if (num_points >= llp_pkg::PATH_DEPTH) return;
      n = num_points;
      path_xs[n] = px;
      path_ys[n] = py;
      num_points = n + 1;
      if (n >= 1) seg_lens[n-1] = span_len(n - 1, n);
      seg_lens[n] = span_len(n, 0);
      return;
    end
    if (num_points < llp_pkg::MIN_POINTS) begin
      push_track(llp_pkg::STATUS_NO_PATH, '0, '0, '0, 1'b1);
      return;
    end
    best = 0;
    best_d = '1;
    for (int unsigned i = 0; i < num_points; i++) begin
      d = sq_dist(px, py, path_xs[i], path_ys[i]);
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    if (best_d > max_dev * max_dev) begin
      push_track(llp_pkg::STATUS_OUTSIDE, '0, '0, '0, 1'b1);
      return;
    end
    heading_trig(hd, co, si);
    idx = best;
    k = 0;
    travelled = 0;
    while (travelled <= horizon && k < num_points && k < llp_pkg::MAX_EMIT) begin
      dx = path_xs[idx] - px;
      dy = path_ys[idx] - py;
      push_track(llp_pkg::STATUS_OK, round_clip(co * dx + si * dy),
                 round_clip(-si * dx + co * dy), idx[9:0], 1'b0);
      k++;
      travelled += seg_lens[idx];
      idx = (idx + 1 >= num_points) ? 0 : idx + 1;
    end
    track_q[track_q.size()-1].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    track_point_t t;
    if (rst_n && out_valid) begin
      if (track_q.size() == 0) begin
        $display("%0t: unexpected result status %0d x %0d y %0d idx %0d last %0b", $time,
                 out_status, out_local_x, out_local_y, out_point_index, out_last);
        errors++;
      end else begin
        t = track_q.pop_front();
        if (out_status !== t.status) begin
          $display("%0t: status exp %0d act %0d", $time, t.status, out_status);
          errors++;
        end
        if (out_local_x !== t.lx) begin
          $display("%0t: local_x exp %0d act %0d", $time, $signed(t.lx), out_local_x);
          errors++;
        end
        if (out_local_y !== t.ly) begin
          $display("%0t: local_y exp %0d act %0d", $time, $signed(t.ly), out_local_y);
          errors++;
        end
        if (out_point_index !== t.idx) begin
          $display("%0t: point_index exp %0d act %0d", $time, t.idx, out_point_index);
          errors++;
        end
        if (out_last !== t.last) begin
          $display("%0t: last exp %0b act %0b", $time, t.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("local_lookahead_path_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic rt, longint x, longint y, int unsigned hd, logic rs);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= rt;
    in_coord_x <= x[23:0];
    in_coord_y <= y[23:0];
    in_heading <= hd[15:0];
    in_restart <= rs;
    do @(posedge clk); while (busy);
    predict_path(rt, x, y, hd, rs);
    if (rt == llp_pkg::REQ_LOAD) begin
      if (rs) begin
        aim_x.delete();
        aim_y.delete();
      end
      if (aim_x.size() < llp_pkg::PATH_DEPTH) begin
        aim_x = {aim_x, x};
        aim_y = {aim_y, y};
      end
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (track_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic ri, int unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= val[llp_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (ri == llp_pkg::CFG_HORIZON) horizon = val;
    else max_dev = val;
  endtask

  function automatic longint rand_coord();
    return longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
  endfunction

  task automatic query_near(int unsigned j, longint spread);
    longint ox;
    longint oy;
    ox = (spread > 0) ? longint'($urandom_range(0, 2 * spread)) - spread : 0;
    oy = (spread > 0) ? longint'($urandom_range(0, 2 * spread)) - spread : 0;
    send_item(llp_pkg::REQ_QUERY, aim_x[j] + ox, aim_y[j] + oy, $urandom_range(0, 65535),
              $urandom_range(0, 1));
  endtask

  task automatic test_few_points;
    send_item(llp_pkg::REQ_QUERY, 0, 0, 0, 1'b0);
    send_item(llp_pkg::REQ_LOAD, 100, 200, 65535, 1'b1);
    send_item(llp_pkg::REQ_QUERY, 100, 200, 0, 1'b1);
    send_item(llp_pkg::REQ_LOAD, 300, 200, 0, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 300, 200, 16384, 1'b0);
  endtask

  task automatic test_headings;
    send_item(llp_pkg::REQ_LOAD, 0, 0, 0, 1'b1);
    send_item(llp_pkg::REQ_LOAD, 1000, 0, 0, 1'b0);
    send_item(llp_pkg::REQ_LOAD, 1000, 1000, 0, 1'b0);
    send_item(llp_pkg::REQ_LOAD, 0, 1000, 0, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 10, 5, 0, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 10, 5, 16384, 1'b1);
    send_item(llp_pkg::REQ_QUERY, 1000, 1000, 32768, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 0, 1000, 49152, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 500, 500, 65535, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 5000, 5000, 8192, 1'b0);
  endtask

  task automatic test_limits;
    write_reg(llp_pkg::CFG_MAXDEV, 0);
    write_reg(llp_pkg::CFG_HORIZON, 0);
    send_item(llp_pkg::REQ_QUERY, 1000, 0, 12345, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 1001, 0, 12345, 1'b0);
    write_reg(llp_pkg::CFG_MAXDEV, CFG_MAX);
    write_reg(llp_pkg::CFG_HORIZON, CFG_MAX);
    send_item(llp_pkg::REQ_LOAD, COORD_MIN, COORD_MIN, 0, 1'b1);
    send_item(llp_pkg::REQ_LOAD, COORD_MAX, COORD_MAX, 0, 1'b0);
    send_item(llp_pkg::REQ_LOAD, COORD_MAX, COORD_MIN, 0, 1'b0);
    send_item(llp_pkg::REQ_LOAD, COORD_MIN, COORD_MAX, 0, 1'b0);
    send_item(llp_pkg::REQ_QUERY, COORD_MIN, COORD_MIN, 8192, 1'b0);
    send_item(llp_pkg::REQ_QUERY, COORD_MAX, COORD_MAX, 40000, 1'b0);
    send_item(llp_pkg::REQ_QUERY, 0, 0, 65535, 1'b0);
    write_reg(llp_pkg::CFG_MAXDEV, 1);
    send_item(llp_pkg::REQ_QUERY, 0, 0, 0, 1'b0);
  endtask

  task automatic test_long_path;
    longint x;
    longint y;
    write_reg(llp_pkg::CFG_MAXDEV, 4096);
    write_reg(llp_pkg::CFG_HORIZON, 200000);
    x = 0;
    y = 0;
    send_item(llp_pkg::REQ_LOAD, x, y, 0, 1'b1);
    for (int i = 1; i < LONG_POINTS; i++) begin
      x += longint'($urandom_range(0, 4000)) - 1000;
      y += longint'($urandom_range(0, 4000)) - 2000;
      send_item(llp_pkg::REQ_LOAD, x, y, $urandom_range(0, 65535), 1'b0);
    end
    query_near(LONG_POINTS - 3, 300);
    query_near(0, 300);
    query_near(LONG_POINTS / 2, 0);
    drain();
  endtask

  task automatic test_random_phase(int pct, int rounds);
    int npts;
    longint x;
    longint y;
    idle_pct = pct;
    case ($urandom_range(0, 3))
      0: write_reg(llp_pkg::CFG_HORIZON, 0);
      1: write_reg(llp_pkg::CFG_HORIZON, CFG_MAX);
      default: write_reg(llp_pkg::CFG_HORIZON, $urandom_range(0, 30000));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(llp_pkg::CFG_MAXDEV, 0);
      1: write_reg(llp_pkg::CFG_MAXDEV, CFG_MAX);
      default: write_reg(llp_pkg::CFG_MAXDEV, $urandom_range(64, 4096));
    endcase
    for (int r = 0; r < rounds; r++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item($urandom_range(0, 1), rand_coord(), rand_coord(), $urandom_range(0, 65535),
                  $urandom_range(0, 1));
      end else begin
        npts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
        x = longint'($urandom_range(0, 8000000)) - 4000000;
        y = longint'($urandom_range(0, 8000000)) - 4000000;
        send_item(llp_pkg::REQ_LOAD, x, y, $urandom_range(0, 65535), 1'b1);
        for (int i = 1; i < npts; i++) begin
          x += longint'($urandom_range(0, 4096)) - 2048;
          y += longint'($urandom_range(0, 4096)) - 2048;
          send_item(llp_pkg::REQ_LOAD, x, y, $urandom_range(0, 65535), 1'b0);
        end
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0)
            send_item(llp_pkg::REQ_QUERY, rand_coord(), rand_coord(),
                      $urandom_range(0, 65535), 1'b0);
          else
            query_near($urandom_range(0, aim_x.size() - 1),
                       longint'(max_dev > 8000 ? 4000 : max_dev / 2));
        end
      end
    end
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    num_points = 0;
    horizon = llp_pkg::HORIZON_RST;
    max_dev = llp_pkg::MAXDEV_RST;
    foreach (path_xs[i]) begin
      path_xs[i] = 0;
      path_ys[i] = 0;
      seg_lens[i] = 0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = llp_pkg::REQ_LOAD;
    in_coord_x = '0;
    in_coord_y = '0;
    in_heading = '0;
    in_restart = 1'b0;
    cfg_we = 1'b0;
    cfg_index = llp_pkg::CFG_HORIZON;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_few_points();
    test_headings();
    test_limits();
    test_long_path();
    test_random_phase(0, 5);
    test_random_phase(80, 5);
    test_random_phase(0, 5);
    test_random_phase(7, 5);
    test_random_phase(0, 4);
    drain();
    if (errors == 0)
      $display("local_lookahead_path_test OK");
    else
      $display("local_lookahead_path_test NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
src/llp_pkg.sv
src/local_lookahead_path.sv
src/llp_chk.sv
test/local_lookahead_path_test.sv
